// File: sv/assert_macros.svh
// Assertion macros shared by the handle slot table RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active-low reset).
`define HST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hst_pkg.sv
// Shared types and constants for the handle slot table.
// Used by hst_store, hst_ctrl and handle_slot_table_unit; no dependencies.
package hst_pkg;

    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_CONTAINS = 3'd2,
        ACT_GET      = 3'd3,
        ACT_PUT      = 3'd4,
        ACT_CLEAR    = 3'd5
    } t_action;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // Control from the sequencer to the slot store.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr_one;
        logic clr_all;
    } t_store_ctl;

endpackage

// File: sv/hst_store.sv
// Slot store: handle memory with one registered read port and per-slot valid bits.
// Depends on hst_pkg. An invalid slot reads as zero (empty).
module hst_store #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 32,
    parameter int IW          = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hst_pkg::t_store_ctl     i_ctl,
    input  logic [IW-1:0]           i_addr,
    input  logic [HANDLE_BITS-1:0]  i_wdata,
    output logic [HANDLE_BITS-1:0]  o_rdata,
    output logic                    o_full
);
    import hst_pkg::*;

    logic [HANDLE_BITS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]       r_valid;
    logic [HANDLE_BITS-1:0] r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_ctl.rd) begin
                r_rvld <= r_valid[i_addr];
            end
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                // a zero handle leaves the slot empty
                r_valid[i_addr] <= (i_wdata != '0);
            end else if (i_ctl.clr_one) begin
                r_valid[i_addr] <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;
    assign o_full  = &r_valid;

endmodule

// File: sv/hst_ctrl.sv
// Sequencer for the handle slot table: scans the store one slot per cycle
// through a shared compare unit. Depends on hst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hst_ctrl #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 32,
    parameter int IW          = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hst_pkg::ACTION_W-1:0]  i_action,
    input  logic [HANDLE_BITS-1:0]        i_key,
    input  logic [hst_pkg::SLOT_W-1:0]    i_slot,
    output logic                          o_idle,
    output logic                          o_done,
    input  logic                          i_take,
    output logic                          o_status,
    output logic [hst_pkg::SLOT_W-1:0]    o_sidx,
    output logic [hst_pkg::HANDLE_W-1:0]  o_hout,
    output logic                          o_full,
    output hst_pkg::t_store_ctl           o_ctl,
    output logic [IW-1:0]                 o_addr,
    output logic [HANDLE_BITS-1:0]        o_wdata,
    input  logic [HANDLE_BITS-1:0]        i_rdata,
    input  logic                          i_full
);
    import hst_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0]     CNT_END  = CW'(SLOTS);
    localparam logic [SLOT_W:0]   SLOT_LIM = (SLOT_W + 1)'(SLOTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_READ  = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } t_seq_state;

    t_seq_state              r_state,  n_state;
    logic [ACTION_W-1:0]     r_act,    n_act;
    logic [HANDLE_BITS-1:0]  r_key,    n_key;
    logic [SLOT_W-1:0]       r_slot,   n_slot;
    logic [CW-1:0]           r_cnt,    n_cnt;
    logic                    r_pend,   n_pend;
    logic [IW-1:0]           r_pidx,   n_pidx;
    logic                    r_found,  n_found;
    logic [IW-1:0]           r_pos,    n_pos;
    logic                    r_efound, n_efound;
    logic [IW-1:0]           r_epos,   n_epos;
    logic                    r_status, n_status;
    logic [SLOT_W-1:0]       r_sidx,   n_sidx;
    logic [HANDLE_W-1:0]     r_hout,   n_hout;

    logic slot_ok;
    logic hit;
    logic empty;

    assign slot_ok = ({1'b0, i_slot} < SLOT_LIM);
    // shared compare unit
    assign hit   = (i_rdata == r_key);
    assign empty = (i_rdata == '0);

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_key    = r_key;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_found  = r_found;
        n_pos    = r_pos;
        n_efound = r_efound;
        n_epos   = r_epos;
        n_status = r_status;
        n_sidx   = r_sidx;
        n_hout   = r_hout;
        o_ctl    = '0;
        o_addr   = r_slot[IW-1:0];
        o_wdata  = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act    = i_action;
                    n_key    = i_key;
                    n_slot   = i_slot;
                    n_cnt    = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    n_efound = 1'b0;
                    n_status = STAT_FAIL;
                    n_sidx   = '0;
                    n_hout   = '0;
                    if (i_action == ACT_ADD || i_action == ACT_REMOVE ||
                        i_action == ACT_CONTAINS) begin
                        n_state = S_SCAN;
                    end else if ((i_action == ACT_GET || i_action == ACT_PUT) && slot_ok) begin
                        n_state = S_READ;
                    end else if (i_action == ACT_CLEAR) begin
                        o_ctl.clr_all = 1'b1;
                        n_status      = STAT_OK;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while checking the previous one
                if (r_cnt < CNT_END) begin
                    o_ctl.rd = 1'b1;
                    o_addr   = r_cnt[IW-1:0];
                    n_cnt    = r_cnt + 1'b1;
                    n_pend   = 1'b1;
                    n_pidx   = r_cnt[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (hit && !r_found) begin
                        n_found = 1'b1;
                        n_pos   = r_pidx;
                    end
                    if (empty && !r_efound) begin
                        n_efound = 1'b1;
                        n_epos   = r_pidx;
                    end
                end
                if (!r_pend && r_cnt == CNT_END) begin
                    n_state = S_DONE;
                    if (r_act == ACT_ADD) begin
                        if (r_efound && !r_found) begin
                            o_ctl.wr = 1'b1;
                            o_addr   = r_epos;
                            n_status = STAT_OK;
                            n_sidx   = SLOT_W'(r_epos);
                        end
                    end else if (r_act == ACT_REMOVE) begin
                        if (r_found) begin
                            o_ctl.clr_one = 1'b1;
                            o_addr        = r_pos;
                            n_status      = STAT_OK;
                        end
                    end else begin
                        n_status = r_found ? STAT_OK : STAT_FAIL;
                    end
                end
            end
            S_READ: begin
                o_ctl.rd = 1'b1;
                n_state  = S_FETCH;
            end
            S_FETCH: begin
                n_hout   = HANDLE_W'(i_rdata);
                n_status = STAT_OK;
                if (r_act == ACT_PUT) begin
                    o_ctl.wr = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_key    <= n_key;
        r_slot   <= n_slot;
        r_pidx   <= n_pidx;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_efound <= n_efound;
        r_epos   <= n_epos;
        r_status <= n_status;
        r_sidx   <= n_sidx;
        r_hout   <= n_hout;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_status;
    assign o_sidx   = r_sidx;
    assign o_hout   = r_hout;
    assign o_full   = i_full;

    `HST_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) |-> !(o_ctl.wr || o_ctl.clr_one), "table modified while idle")
    `HST_ASSERT(a_take_to_idle, i_clk, i_rst_n, (o_done && i_take) |=> (r_state == S_IDLE), "sequencer did not return to idle after handoff")
    `HST_ASSERT(a_scan_write_add, i_clk, i_rst_n, (r_state == S_SCAN && o_ctl.wr) |-> (r_act == ACT_ADD && !r_found && r_efound), "scan wrote a slot without a valid add")
    `HST_ASSERT(a_scan_count, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_cnt <= CNT_END), "scan counter ran past the table")

endmodule

// File: sv/handle_slot_table_unit.sv
// Handle slot table top level: sequencer, slot store and result register.
// Depends on hst_pkg, hst_store, hst_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat of action, handle
//   and slot. Output channel (o_out_valid / i_out_ready) returns exactly one
//   beat per input: status, slot_index, handle_out and full_res.
//   Add, remove and contains scan every slot through one compare unit, one
//   slot per cycle, a rate set by the single read port of the store.
//   Get and put pass through a read and a fetch step; clear, bad indexes
//   and unused actions go straight to the done step.
//   o_in_ready is high only while the sequencer is idle; one item is in work
//   at a time.
//   The result register decouples the sides: a new beat is taken while a
//   finished result waits, and a stalled receiver only holds the sequencer
//   at its final step once its next result is ready.
//   Reset (i_rst_n low, synchronous) empties every slot at once through the
//   per-slot valid bits and drops any pending result.
module handle_slot_table_unit #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hst_pkg::ACTION_W-1:0]  i_action,
    input  logic [hst_pkg::HANDLE_W-1:0]  i_handle,
    input  logic [hst_pkg::SLOT_W-1:0]    i_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic [hst_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [hst_pkg::HANDLE_W-1:0]  o_handle_out,
    output logic                          o_full_res
);
    import hst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_store_ctl              store_ctl;
    logic [IW-1:0]           store_addr;
    logic [HANDLE_BITS-1:0]  store_wdata;
    logic [HANDLE_BITS-1:0]  store_rdata;
    logic                    store_full;

    logic                    seq_idle;
    logic                    seq_done;
    logic                    seq_status;
    logic [SLOT_W-1:0]       seq_sidx;
    logic [HANDLE_W-1:0]     seq_hout;
    logic                    seq_full;
    logic                    take;

    logic                    r_ovalid;
    logic                    r_status;
    logic [SLOT_W-1:0]       r_sidx;
    logic [HANDLE_W-1:0]     r_hout;
    logic                    r_full;

    hst_store #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS),
        .IW          (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (store_ctl),
        .i_addr  (store_addr),
        .i_wdata (store_wdata),
        .o_rdata (store_rdata),
        .o_full  (store_full)
    );

    hst_ctrl #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS),
        .IW          (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && o_in_ready),
        .i_action (i_action),
        .i_key    (HANDLE_BITS'(i_handle)),
        .i_slot   (i_slot),
        .o_idle   (seq_idle),
        .o_done   (seq_done),
        .i_take   (take),
        .o_status (seq_status),
        .o_sidx   (seq_sidx),
        .o_hout   (seq_hout),
        .o_full   (seq_full),
        .o_ctl    (store_ctl),
        .o_addr   (store_addr),
        .o_wdata  (store_wdata),
        .i_rdata  (store_rdata),
        .i_full   (store_full)
    );

    // move the finished result into the output register when it is free
    assign take = seq_done && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= seq_status;
            r_sidx   <= seq_sidx;
            r_hout   <= seq_hout;
            r_full   <= seq_full;
        end
    end

    assign o_in_ready   = seq_idle;
    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_slot_index = r_sidx;
    assign o_handle_out = r_hout;
    assign o_full_res   = r_full;

endmodule
